/* hdl/tfs_pkg.sv */
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types and constants of the target-follow set-point generator.
// ----------------------------------------------------------------------------
package tfs_pkg;

   // Width of a magnitude dividend: |33-bit value| * 10^6 stays below 2^52.
   localparam int NUM_BITS = 53;
   // Width of a divisor: interval sums and 65536 + |d| fit in 33 bits.
   localparam int DEN_BITS = 33;
   // Bit counter of the serial divider.
   localparam int CNT_BITS = 6;

   localparam logic [19:0]         US_PER_S = 20'd1000000;
   localparam logic [DEN_BITS-1:0] Q_ONE    = DEN_BITS'(65536);

   localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;

   // Sample kinds on req_op.
   localparam logic OP_TARGET   = 1'b0;
   localparam logic OP_FOLLOWER = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_POST,
      ST_DONE
   } state_type;

   // Quotients that one item may need, in the order they are formed.
   typedef enum logic [1:0] {
      JB_VEL,
      JB_ACC,
      JB_SX,
      JB_SY
   } job_type;

endpackage

/* hdl/target_follow_setpoint_top.sv */
// ----------------------------------------------------------------------------
// target_follow_setpoint_top
// Target-follow set-point generator with a shared bit-serial divider.
// ----------------------------------------------------------------------------
// Each accepted request is a target or a follower position sample (Q16.16,
// stamps in microseconds). A target sample replaces the target position and
// derives x velocity and x acceleration by finite differences; a follower
// sample replaces the follower position. Every request gives one response
// with cmd_x = acc/2 + vel + s(dx), cmd_y = s(dy), cmd_z = dz, where
// s(d) = d / (1 + |d|) and d = follower - target; all outputs saturate.
// All quotients share one restoring divider that retires one quotient bit
// per cycle over a 53-bit dividend; each quotient passes through setup, 53
// shift steps and post. A target request needs four quotients; a follower
// request needs two. A zero interval yields a zero velocity or acceleration
// without running the divider, as setup then goes straight to post. One
// request is worked at a time; the response sits in an output register so
// the next request may start while the previous response is still stalled.
// ----------------------------------------------------------------------------
module target_follow_setpoint_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_stamp_us,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_cmd_x,
   output logic [31:0] rsp_cmd_y,
   output logic [31:0] rsp_cmd_z
);
   import tfs_pkg::*;

   // Sequencer
   state_type state_ff, state_in;
   job_type   job_ff, job_in;

   // Stored positions and target rates
   logic [31:0] tpos_x_ff, tpos_y_ff, tpos_z_ff;
   logic [31:0] fpos_x_ff, fpos_y_ff, fpos_z_ff;
   logic [31:0] last_time_ff;
   logic [31:0] prev_itv_ff;
   logic [31:0] vel_ff;
   logic [31:0] acc_ff;

   // Per-request working values
   logic [32:0] dpos_ff;     // signed x position change
   logic [31:0] itv_ff;      // current interval
   logic [32:0] span_ff;     // sum of the last two intervals
   logic [32:0] vdiff_ff;    // signed velocity change
   logic [31:0] sx_ff, sy_ff;

   // Serial divider
   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                neg_ff;

   // Response register
   logic        rsp_valid_ff;
   logic [31:0] cmd_x_ff, cmd_y_ff, cmd_z_ff;

   // Control decoded from state
   logic accept;
   logic setup;
   logic post;
   logic load_rsp;

   // Setup path
   logic signed [32:0] opd;
   logic [32:0]        mag;
   logic               den_zero;
   logic [31:0]        itv_new;

   // Divide step
   logic [DEN_BITS:0] rem_t;
   logic              ge;

   // Post path
   logic [31:0] res;
   logic [32:0] vdiff_new;

   // Sum path
   logic signed [32:0] acc_half;
   logic signed [33:0] xsum;
   logic signed [32:0] dz;
   logic [31:0]        xsat, zsat;

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SETUP;
         ST_SETUP: state_in = den_zero ? ST_POST : ST_DIV;
         ST_DIV:   if (cnt_ff == CNT_BITS'(NUM_BITS - 1)) state_in = ST_POST;
         ST_POST:  state_in = (job_ff == JB_SY) ? ST_DONE : ST_SETUP;
         ST_DONE:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // State outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_stall = 1'b1;
      setup     = 1'b0;
      post      = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_SETUP: setup = 1'b1;
         ST_POST:  post = 1'b1;
         ST_DONE:  load_rsp = !rsp_valid_ff || !rsp_stall;
         default:  req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   // Job after the current one; a follower request starts at the soft terms.
   always_comb begin
      job_in = job_ff;
      if (accept) begin
         job_in = (req_op == OP_FOLLOWER) ? JB_SX : JB_VEL;
      end else if (post) begin
         case (job_ff)
            JB_VEL:  job_in = JB_ACC;
            JB_ACC:  job_in = JB_SX;
            JB_SX:   job_in = JB_SY;
            default: job_in = JB_SY;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= JB_VEL;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   // ------------------------------------------------------------------
   // Request capture: positions update at once, the interval and the
   // x position change are held for the rate quotients.
   // ------------------------------------------------------------------
   assign itv_new = req_stamp_us - last_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpos_x_ff    <= '0;
         tpos_y_ff    <= '0;
         tpos_z_ff    <= '0;
         fpos_x_ff    <= '0;
         fpos_y_ff    <= '0;
         fpos_z_ff    <= '0;
         last_time_ff <= '0;
         prev_itv_ff  <= '0;
      end else if (accept) begin
         if (req_op == OP_TARGET) begin
            tpos_x_ff    <= req_pos_x;
            tpos_y_ff    <= req_pos_y;
            tpos_z_ff    <= req_pos_z;
            last_time_ff <= req_stamp_us;
            prev_itv_ff  <= itv_new;
         end else begin
            fpos_x_ff <= req_pos_x;
            fpos_y_ff <= req_pos_y;
            fpos_z_ff <= req_pos_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dpos_ff <= {req_pos_x[31], req_pos_x} - {tpos_x_ff[31], tpos_x_ff};
         itv_ff  <= itv_new;
         span_ff <= {1'b0, itv_new} + {1'b0, prev_itv_ff};
      end
   end

   // ------------------------------------------------------------------
   // Setup: pick the operand, take its magnitude, scale it and pick the
   // divisor for the current job.
   // ------------------------------------------------------------------
   always_comb begin
      case (job_ff)
         JB_VEL:  opd = $signed(dpos_ff);
         JB_ACC:  opd = $signed(vdiff_ff);
         JB_SX:   opd = $signed({fpos_x_ff[31], fpos_x_ff} - {tpos_x_ff[31], tpos_x_ff});
         default: opd = $signed({fpos_y_ff[31], fpos_y_ff} - {tpos_y_ff[31], tpos_y_ff});
      endcase
      mag = opd[32] ? 33'(-opd) : 33'(opd);
      case (job_ff)
         JB_VEL: begin
            num_in = {{(NUM_BITS-33){1'b0}}, mag} * US_PER_S;
            den_in = DEN_BITS'({1'b0, itv_ff});
         end
         JB_ACC: begin
            num_in = {{(NUM_BITS-33){1'b0}}, mag} * US_PER_S;
            den_in = span_ff;
         end
         default: begin
            num_in = {{(NUM_BITS-49){1'b0}}, mag, 16'b0};
            den_in = Q_ONE + mag;
         end
      endcase
      den_zero = (den_in == '0);
   end

   // ------------------------------------------------------------------
   // Restoring divider: shift one dividend bit into the remainder each
   // cycle, shift the quotient bit in behind it.
   // ------------------------------------------------------------------
   assign rem_t  = {rem_ff, num_ff[NUM_BITS-1]};
   assign ge     = rem_t >= {1'b0, den_ff};
   assign rem_in = ge ? DEN_BITS'(rem_t - {1'b0, den_ff}) : rem_t[DEN_BITS-1:0];

   always_ff @(posedge clock) begin
      if (setup) begin
         num_ff <= den_zero ? '0 : num_in;
         den_ff <= den_in;
         rem_ff <= '0;
         cnt_ff <= '0;
         neg_ff <= opd[32];
      end else if (state_ff == ST_DIV) begin
         num_ff <= {num_ff[NUM_BITS-2:0], ge};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
   end

   // ------------------------------------------------------------------
   // Post: restore the sign and saturate the quotient, then file it.
   // ------------------------------------------------------------------
   always_comb begin
      if (!neg_ff) begin
         res = (num_ff > NUM_BITS'(S32_MAX)) ? S32_MAX : num_ff[31:0];
      end else begin
         res = (num_ff > NUM_BITS'(S32_MIN)) ? S32_MIN : 32'(-num_ff[31:0]);
      end
      vdiff_new = {res[31], res} - {vel_ff[31], vel_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff <= '0;
         acc_ff <= '0;
      end else if (post) begin
         case (job_ff)
            JB_VEL:  vel_ff <= res;
            JB_ACC:  acc_ff <= res;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (post) begin
         case (job_ff)
            JB_VEL:  vdiff_ff <= vdiff_new;
            JB_SX:   sx_ff <= res;
            JB_SY:   sy_ff <= res;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Final sums: halve acc toward zero, add velocity and soft x term,
   // saturate; z is the plain saturated difference.
   // ------------------------------------------------------------------
   always_comb begin
      acc_half = ($signed({acc_ff[31], acc_ff}) + $signed({32'b0, acc_ff[31]})) >>> 1;
      xsum = $signed({acc_half[32], acc_half})
           + $signed({{2{vel_ff[31]}}, vel_ff})
           + $signed({{2{sx_ff[31]}}, sx_ff});
      if (xsum > $signed({2'b00, S32_MAX})) begin
         xsat = S32_MAX;
      end else if (xsum < $signed({2'b11, S32_MIN})) begin
         xsat = S32_MIN;
      end else begin
         xsat = xsum[31:0];
      end
      dz = $signed({fpos_z_ff[31], fpos_z_ff} - {tpos_z_ff[31], tpos_z_ff});
      if (dz[32] != dz[31]) begin
         zsat = dz[32] ? S32_MIN : S32_MAX;
      end else begin
         zsat = dz[31:0];
      end
   end

   // Response register: load on completion, drop when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         cmd_x_ff <= xsat;
         cmd_y_ff <= sy_ff;
         cmd_z_ff <= zsat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cmd_x = cmd_x_ff;
   assign rsp_cmd_y = cmd_y_ff;
   assign rsp_cmd_z = cmd_z_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SETUP))
      else $error("accepted request did not start a quotient");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_div_from_zero: assert property (@(posedge clock) disable iff (reset)
      (setup && !den_zero) |=> (cnt_ff == '0))
      else $error("divider started with stale count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside completion");

endmodule

/* tb/tb_target_follow_setpoint_top.sv */
// ----------------------------------------------------------------------------
// tb_target_follow_setpoint_top
// Self-checking bench for the target-follow set-point generator.
// ----------------------------------------------------------------------------
// An initial block queues target and follower samples (directed corners, then
// random ones). A clocked driver offers them on the request channel, a
// clocked monitor takes responses and compares them with the set-points
// worked out by a predictor that keeps its own copy of the tracking state.
// Idling and stalling run through several phases, with a long receiver
// hold-off and a sender pause that drains the block.
// ----------------------------------------------------------------------------
module tb_target_follow_setpoint_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tfs_pkg::*;

   typedef struct packed {
      logic        op;
      logic [31:0] stamp_us;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
   } sample_type;

   typedef struct packed {
      logic [31:0] cmd_x;
      logic [31:0] cmd_y;
      logic [31:0] cmd_z;
   } setpoint_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_TARGET;
   logic [31:0] req_stamp_us = '0;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [31:0] req_pos_z = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_cmd_x;
   logic [31:0] rsp_cmd_y;
   logic [31:0] rsp_cmd_z;

   target_follow_setpoint_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_stamp_us(req_stamp_us), .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cmd_x(rsp_cmd_x), .rsp_cmd_y(rsp_cmd_y), .rsp_cmd_z(rsp_cmd_z)
   );

   always #6 clock = ~clock;

   sample_type   pending_samples[$];
   setpoint_type expected_setpoints[$];

   // Predictor state, mirrors what the block keeps.
   longint trk_target[3];
   longint trk_follower[3];
   logic [31:0] trk_last_stamp;
   logic [31:0] trk_prev_itv;
   longint trk_vel;
   longint trk_acc;

   int  errors = 0;
   int  n_sent = 0;
   int  n_queued = 0;
   int  n_checked = 0;
   int  send_idle_pct = 0;   // percent of cycles the sender stays idle
   int  recv_stall_pct = 0;  // percent of cycles the receiver stalls
   int  hold_cycles = 0;     // long receiver hold-off, counted down below
   int  hold_req = 0;        // bumped by the stimulus to start a hold-off
   int  hold_seen = 0;
   bit  sender_paused = 1'b0;
   longint cycle_count = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint soft_limit(longint d);
      longint mag;
      mag = (d < 0) ? -d : d;
      return (d * 65536) / (65536 + mag);
   endfunction

   // Apply one sample to the tracking state and queue its set-points.
   function automatic void track_sample(sample_type s);
      longint p[3];
      longint dlt[3];
      longint dpos, span, vel, acc, x;
      logic [31:0] itv;
      setpoint_type sp;
      p[0] = longint'($signed(s.pos_x));
      p[1] = longint'($signed(s.pos_y));
      p[2] = longint'($signed(s.pos_z));
      if (s.op == OP_TARGET) begin
         itv = s.stamp_us - trk_last_stamp;
         dpos = p[0] - trk_target[0];
         span = longint'(itv) + longint'(trk_prev_itv);
         vel = 0;
         acc = 0;
         if (itv != 0) vel = clamp32((dpos * 1000000) / longint'(itv));
         if (span != 0) acc = clamp32(((vel - trk_vel) * 1000000) / span);
         trk_last_stamp = s.stamp_us;
         trk_prev_itv = itv;
         trk_vel = vel;
         trk_acc = acc;
         for (int i = 0; i < 3; i++) trk_target[i] = p[i];
      end else begin
         for (int i = 0; i < 3; i++) trk_follower[i] = p[i];
      end
      for (int i = 0; i < 3; i++) dlt[i] = trk_follower[i] - trk_target[i];
      x = trk_acc / 2 + trk_vel + soft_limit(dlt[0]);
      sp.cmd_x = 32'(clamp32(x));
      sp.cmd_y = 32'(soft_limit(dlt[1]));
      sp.cmd_z = 32'(clamp32(dlt[2]));
      expected_setpoints.push_back(sp);
   endfunction

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 40 * 65536)) - 20 * 65536);
      endcase
   endfunction

   function automatic void queue_sample(logic op, logic [31:0] stamp,
                                        logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z);
      sample_type s;
      s.op = op; s.stamp_us = stamp; s.pos_x = x; s.pos_y = y; s.pos_z = z;
      pending_samples.push_back(s);
      n_queued++;
   endfunction

   // Driver: advance to the next sample once the current one is taken.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            track_sample({req_op, req_stamp_us, req_pos_x, req_pos_y, req_pos_z});
            n_sent <= n_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() != 0 && !sender_paused &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               sample_type s;
               s = pending_samples.pop_front();
               req_valid    <= 1'b1;
               req_op       <= s.op;
               req_stamp_us <= s.stamp_us;
               req_pos_x    <= s.pos_x;
               req_pos_y    <= s.pos_y;
               req_pos_z    <= s.pos_z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Hold-off counter: load the long stretch on request, count it down.
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen   <= hold_req;
         hold_cycles <= 1500;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // Monitor: check each response against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_setpoints.size() == 0) begin
               $display("%0t: response with nothing expected x=%h y=%h z=%h",
                        $realtime, rsp_cmd_x, rsp_cmd_y, rsp_cmd_z);
               errors++;
            end else begin
               setpoint_type e;
               e = expected_setpoints.pop_front();
               if (e.cmd_x !== rsp_cmd_x) begin
                  $display("%0t: cmd_x expected %h actual %h", $realtime, e.cmd_x, rsp_cmd_x);
                  errors++;
               end
               if (e.cmd_y !== rsp_cmd_y) begin
                  $display("%0t: cmd_y expected %h actual %h", $realtime, e.cmd_y, rsp_cmd_y);
                  errors++;
               end
               if (e.cmd_z !== rsp_cmd_z) begin
                  $display("%0t: cmd_z expected %h actual %h", $realtime, e.cmd_z, rsp_cmd_z);
                  errors++;
               end
               n_checked++;
            end
         end
         // Hold off for the long stretch first, then stall at random.
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   // Watchdog: end the run with an error once the cycle limit is passed.
   always @(posedge clock) begin
      if (cycle_count > 1000000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[target_follow_setpoint_top] ERROR");
         $finish;
      end
   end

   // Wait until every queued sample has had its response checked.
   task automatic wait_drained();
      while (n_checked < n_queued)
         @(posedge clock);
   endtask

   task automatic queue_random(int count);
      logic [31:0] stamp;
      stamp = trk_last_stamp;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: stamp = $urandom;                          // wrap or jump
            1: ;                                          // zero interval
            default: stamp = stamp + $urandom_range(1, 20000);
         endcase
         queue_sample($urandom_range(0, 2) == 0 ? OP_FOLLOWER : OP_TARGET,
                      stamp, rand_pos(), rand_pos(), rand_pos());
      end
   endtask

   initial begin
      int base_sent;
      for (int i = 0; i < 3; i++) begin
         trk_target[i] = 0;
         trk_follower[i] = 0;
      end
      trk_last_stamp = '0;
      trk_prev_itv = '0;
      trk_vel = 0;
      trk_acc = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: first target from time zero, zero intervals, extremes.
      queue_sample(OP_TARGET,   32'd0,        32'h0001_0000, 32'd0, 32'd0);
      queue_sample(OP_TARGET,   32'd10000,    32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000);
      queue_sample(OP_FOLLOWER, 32'd0,        32'h0003_0000, 32'h0000_8000, 32'h0004_0000);
      queue_sample(OP_TARGET,   32'd10000,    32'h0005_0000, 32'd0, 32'd0);
      queue_sample(OP_TARGET,   32'd10001,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_sample(OP_TARGET,   32'd10002,    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_sample(OP_FOLLOWER, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_sample(OP_TARGET,   32'd5,        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      queue_sample(OP_TARGET,   32'd3,        32'd0, 32'hFFFF_FFFF, 32'h0000_0001);
      queue_sample(OP_TARGET,   32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
      queue_sample(OP_FOLLOWER, 32'hAAAA_5555, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_sample(OP_TARGET,   32'h5555_AAAA, 32'h0000_0001, 32'h1234_5678, 32'hEDCB_A987);
      queue_sample(OP_TARGET,   32'h5555_AAAA, 32'hFFFF_FFFF, 32'd0, 32'd0);
      wait_drained();

      // Long hold-off while the sender keeps offering.
      hold_req++;
      queue_random(20);
      wait_drained();

      // Pause the sender until every response is back, then resume.
      base_sent = n_sent;
      queue_random(10);
      while (n_sent < base_sent + 5) @(posedge clock);
      sender_paused = 1'b1;
      @(posedge clock);
      while (req_valid || n_checked != n_sent) @(posedge clock);
      repeat (20) @(posedge clock);
      sender_paused = 1'b0;
      wait_drained();

      send_idle_pct = 0;  recv_stall_pct = 0;  queue_random(140); wait_drained();
      send_idle_pct = 56; recv_stall_pct = 0;  queue_random(140); wait_drained();
      send_idle_pct = 0;  recv_stall_pct = 56; queue_random(140); wait_drained();
      send_idle_pct = 18; recv_stall_pct = 18; queue_random(140); wait_drained();

      repeat (300) @(posedge clock);
      $display("covered %0d samples (target and follower), %0d responses checked",
               n_sent, n_checked);
      $display("phases: free run, sender idling, receiver stalling, both, long hold-off");
      if (errors == 0 && n_checked == n_queued && expected_setpoints.size() == 0)
         $display("[target_follow_setpoint_top] OK");
      else
         $display("[target_follow_setpoint_top] ERROR");
      $finish;
   end
endmodule

/* sim.f */
hdl/tfs_pkg.sv
hdl/target_follow_setpoint_top.sv
tb/tb_target_follow_setpoint_top.sv
